// ----- design/mvt_pkg.sv -----
`default_nettype none
package mvt_pkg;

    localparam int DATA_W        = 32;
    localparam int PROD_W        = 2 * DATA_W;
    localparam int FRAC_BITS_DEF = 16;
    localparam int N_DIM         = 4;
    localparam int N_ELEM        = N_DIM * N_DIM;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_VEC4  = 2'd1,
        OP_POINT = 2'd2
    } t_op;

    typedef logic signed [DATA_W-1:0] t_word;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef t_word [N_ELEM-1:0]       t_mat;
    typedef t_word [N_DIM-1:0]        t_vec;
    typedef t_prod [N_ELEM-1:0]       t_prods;

    typedef struct packed {
        logic valid;
        logic point;
    } t_stage_ctl;

endpackage
`default_nettype wire

// ----- design/mvt_matrix.sv -----
`default_nettype none
module mvt_matrix
    import mvt_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_we,
    input  wire  [3:0] i_index,
    input  t_word      i_value,
    output t_mat       o_mat
);

    localparam t_word ONE = t_word'(1) <<< FRAC_BITS;

    t_mat r_mat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N_ELEM; i++) begin
                r_mat[i] <= (i % (N_DIM + 1) == 0) ? ONE : '0;
            end
        end else if (i_we) begin
            r_mat[i_index] <= i_value;
        end
    end

    assign o_mat = r_mat;

endmodule
`default_nettype wire

// ----- design/mvt_mult.sv -----
`default_nettype none
module mvt_mult
    import mvt_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    input  wire        i_point,
    input  t_mat       i_mat,
    input  t_vec       i_vec,
    input  wire        i_ready,
    output logic       o_ready,
    output t_stage_ctl o_ctl,
    output t_prods     o_prod
);

    localparam t_word ONE = t_word'(1) <<< FRAC_BITS;

    t_stage_ctl r_ctl;
    t_prods     r_prod;
    t_prods     n_prod;
    t_vec       vec;

    assign o_ready = !r_ctl.valid || i_ready;

    // point: w taken as one, so column three adds as translation
    always_comb begin
        vec    = i_vec;
        vec[3] = i_point ? ONE : i_vec[3];
        for (int i = 0; i < N_ELEM; i++) begin
            n_prod[i] = i_mat[i] * vec[i % N_DIM];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (o_ready) begin
            r_ctl.valid <= i_valid;
            r_ctl.point <= i_point;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_prod <= n_prod;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_prod = r_prod;

endmodule
`default_nettype wire

// ----- design/mvt_reduce.sv -----
`default_nettype none
module mvt_reduce
    import mvt_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  t_stage_ctl i_ctl,
    input  t_prods     i_prod,
    output logic       o_ready,
    output logic       o_valid,
    input  wire        i_ready,
    output t_vec       o_vec,
    output logic       o_sat
);

    localparam t_prod S32_MAX = t_prod'({1'b0, {(DATA_W-1){1'b1}}});
    localparam t_prod S32_MIN = -S32_MAX - t_prod'(1);

    t_stage_ctl r_ctl2;
    t_prod      r_half [N_DIM][2];
    t_prod      n_half [N_DIM][2];
    logic       r_v3;
    t_vec       r_vec;
    logic       r_sat;
    t_vec       n_vec;
    logic       n_sat;
    logic       rdy3;
    t_prod      sum;

    assign rdy3    = !r_v3 || i_ready;
    assign o_ready = !r_ctl2.valid || rdy3;

    // floor shift back to fraction bits, then pair sums
    always_comb begin
        for (int r = 0; r < N_DIM; r++) begin
            for (int h = 0; h < 2; h++) begin
                n_half[r][h] = (i_prod[r*N_DIM + 2*h] >>> FRAC_BITS)
                             + (i_prod[r*N_DIM + 2*h + 1] >>> FRAC_BITS);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl2 <= '0;
        end else if (o_ready) begin
            r_ctl2 <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_ctl.valid) begin
            r_half <= n_half;
        end
    end

    always_comb begin
        n_sat = 1'b0;
        n_vec = '0;
        for (int r = 0; r < N_DIM; r++) begin
            sum = r_half[r][0] + r_half[r][1];
            if (sum > S32_MAX) begin
                n_vec[r] = S32_MAX[DATA_W-1:0];
                if (!(r_ctl2.point && r == N_DIM - 1)) n_sat = 1'b1;
            end else if (sum < S32_MIN) begin
                n_vec[r] = S32_MIN[DATA_W-1:0];
                if (!(r_ctl2.point && r == N_DIM - 1)) n_sat = 1'b1;
            end else begin
                n_vec[r] = sum[DATA_W-1:0];
            end
        end
        if (r_ctl2.point) n_vec[N_DIM-1] = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (rdy3) begin
            r_v3 <= r_ctl2.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3 && r_ctl2.valid) begin
            r_vec <= n_vec;
            r_sat <= n_sat;
        end
    end

    assign o_valid = r_v3;
    assign o_vec   = r_vec;
    assign o_sat   = r_sat;

endmodule
`default_nettype wire

// ----- design/matrix4_vector_transform.sv -----
// 4x4 fixed-point matrix times vector engine.
// Slave channel (i_s_*): one word per item; tuser carries the op code
// (write element, transform vec4, transform point), tdata the element
// index/value and the x, y, z, w components. Master channel (o_m_*):
// tdata carries x, y, z, w results, tuser the saturation flag.
// Write items update the matrix at acceptance and give no result; the
// next item already sees the new element. Unused op code three is dropped.
// Throughput: one item per cycle while the master side keeps taking results.
// Each result passes through three registers before o_m_tvalid rises
// (product register, pair-sum register, final sum and clip register).
// Reset: matrix returns to identity, pipeline is emptied.
// Stall: each stage holds while its successor is full and stalled; bubbles
// collapse, so the input keeps accepting until all three stages are full.
`default_nettype none
module matrix4_vector_transform
    import mvt_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_s_tvalid,
    output logic         o_s_tready,
    // elem_index[3:0], elem_value[35:4], in_x[67:36], in_y[99:68],
    // in_z[131:100], in_w[163:132], zero pad[167:164]
    input  wire  [167:0] i_s_tdata,
    // op[1:0]
    input  wire  [1:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  wire          i_m_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64], out_w[127:96]
    output logic [127:0] o_m_tdata,
    // saturated[0]
    output logic [0:0]   o_m_tuser
);

    t_op        op;
    logic       accept;
    logic       xform;
    t_mat       mat;
    t_vec       vec_in;
    t_stage_ctl ctl1;
    t_prods     prod;
    logic       rdy2;
    t_vec       vec_out;
    logic       sat;

    assign op     = t_op'(i_s_tuser);
    assign accept = i_s_tvalid && o_s_tready;

    always_comb begin
        case (op)
            OP_VEC4, OP_POINT: xform = 1'b1;
            default:           xform = 1'b0;
        endcase
    end

    assign vec_in[0] = i_s_tdata[67:36];
    assign vec_in[1] = i_s_tdata[99:68];
    assign vec_in[2] = i_s_tdata[131:100];
    assign vec_in[3] = i_s_tdata[163:132];

    mvt_matrix #(.FRAC_BITS(FRAC_BITS)) u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (accept && (op == OP_WRITE)),
        .i_index (i_s_tdata[3:0]),
        .i_value (i_s_tdata[35:4]),
        .o_mat   (mat)
    );

    mvt_mult #(.FRAC_BITS(FRAC_BITS)) u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid && xform),
        .i_point (op == OP_POINT),
        .i_mat   (mat),
        .i_vec   (vec_in),
        .i_ready (rdy2),
        .o_ready (o_s_tready),
        .o_ctl   (ctl1),
        .o_prod  (prod)
    );

    mvt_reduce #(.FRAC_BITS(FRAC_BITS)) u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl1),
        .i_prod  (prod),
        .o_ready (rdy2),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_vec   (vec_out),
        .o_sat   (sat)
    );

    assign o_m_tdata = {vec_out[3], vec_out[2], vec_out[1], vec_out[0]};
    assign o_m_tuser = sat;

endmodule
`default_nettype wire
